[hdl/lcdq_pkg.sv]
`timescale 1ns / 1ps

package lcdq_pkg;

  localparam int QDEPTH    = 16;
  localparam int QIDX_W    = $clog2(QDEPTH);
  localparam int COLUMNS   = 16;
  localparam int COL_W     = $clog2(COLUMNS + 1);
  localparam int ROWS      = 4;
  localparam int ROW_W     = 3;
  localparam int ROWSEL_W  = $clog2(ROWS);
  localparam int ADDR_W    = 7;
  localparam int CNT_OUT_W = 4;

  typedef logic [QIDX_W-1:0] qidx_t;
  typedef logic [QIDX_W:0]   qcnt_t;
  typedef logic [8:0]        cmd_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_CURSOR = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_POLL   = 3'd3,
    OP_RAW    = 3'd4
  } op_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam addr_t ROW_BASE_RST [ROWS] = '{7'h00, 7'h10, 7'h08, 7'h18};

  typedef struct packed {
    logic [1:0] push_n;
    cmd_t       d0;
    cmd_t       d1;
    logic       pop;
  } q_req_t;

  typedef struct packed {
    qcnt_t count;
    qcnt_t free;
    cmd_t  head;
  } q_stat_t;

  function automatic qidx_t slot_inc(qidx_t i);
    return (i == qidx_t'(QDEPTH - 1)) ? '0 : qidx_t'(i + 1'b1);
  endfunction

endpackage

[hdl/lcdq_queue.sv]
`timescale 1ns / 1ps

module lcdq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lcdq_pkg::q_req_t  req,
  output lcdq_pkg::q_stat_t stat
);
  import lcdq_pkg::*;

  qidx_t w_r, w_nxt;
  qidx_t r_r, r_nxt;
  cmd_t  store_r [QDEPTH];
  qidx_t slot1;
  qidx_t slot2;

  assign slot1 = slot_inc(w_r);
  assign slot2 = slot_inc(slot1);

  always_comb begin
    if (w_r >= r_r) begin
      stat.count = qcnt_t'(w_r) - qcnt_t'(r_r);
    end else begin
      stat.count = qcnt_t'(QDEPTH) - (qcnt_t'(r_r) - qcnt_t'(w_r));
    end
    stat.free = qcnt_t'(QDEPTH - 1) - stat.count;
    stat.head = store_r[slot_inc(r_r)];
  end

  always_comb begin
    case (req.push_n)
      2'd1:    w_nxt = slot1;
      2'd2:    w_nxt = slot2;
      default: w_nxt = w_r;
    endcase
    r_nxt = req.pop ? slot_inc(r_r) : r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      r_r <= '0;
    end else begin
      w_r <= w_nxt;
      r_r <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push_n != 2'd0) begin
      store_r[slot1] <= req.d0;
    end
    if (req.push_n == 2'd2) begin
      store_r[slot2] <= req.d1;
    end
  end

endmodule

[hdl/lcdq_ctrl.sv]
`timescale 1ns / 1ps

module lcdq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [6:0]               cfg_wdata,
  input  logic [2:0]               op,
  input  logic [7:0]               char_code,
  input  logic                     raw_rs,
  input  logic [4:0]               cursor_col,
  input  logic [2:0]               cursor_row,
  input  logic                     busy_req,
  input  lcdq_pkg::q_stat_t        qstat,
  output lcdq_pkg::q_req_t         qreq,
  output logic [1:0]               status,
  output logic                     port_write,
  output logic                     port_rs,
  output logic [7:0]               port_data,
  output logic [lcdq_pkg::CNT_OUT_W-1:0] queued_count
);
  import lcdq_pkg::*;

  addr_t            base_r [ROWS];
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             nl_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             nl_nxt;
  logic [1:0]       push_n;
  logic             pop;
  cmd_t             cmd_v [2];
  qcnt_t            count_after;

  always_comb begin
    logic [1:0]       k;
    logic             abort;
    logic [ROW_W-1:0] nr;
    addr_t            addr;

    k       = 2'd0;
    abort   = 1'b0;
    nr      = '0;
    addr    = '0;
    col_nxt = col_r;
    row_nxt = row_r;
    nl_nxt  = nl_r;
    pop     = 1'b0;
    status  = ST_OK;
    cmd_v[0] = '0;
    cmd_v[1] = '0;

    case (op_e'(op))
      OP_CHAR: begin
        if (nl_r) begin
          nr = row_r + 1'b1;
          if (int'(nr) < ROWS) begin
            if (qstat.free > qcnt_t'(k)) begin
              cmd_v[k[0]] = {1'b0, CMD_SET_ADDR | {1'b0, base_r[nr[ROWSEL_W-1:0]]}};
              k = k + 1'b1;
            end else begin
              abort = 1'b1;
            end
          end
          if (!abort) begin
            col_nxt = '0;
            row_nxt = nr;
            nl_nxt  = 1'b0;
          end
        end
        if (!abort && int'(row_nxt) >= ROWS) begin
          if (qstat.free > qcnt_t'(k)) begin
            cmd_v[k[0]] = {1'b0, CMD_CLEAR};
            k = k + 1'b1;
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            abort = 1'b1;
          end
        end
        if (!abort) begin
          if (char_code == CH_NEWLINE) begin
            nl_nxt = 1'b1;
          end else if (char_code == CH_BACKSPACE) begin
            if (col_nxt != '0) begin
              col_nxt = col_nxt - 1'b1;
            end
          end else if (qstat.free > qcnt_t'(k)) begin
            cmd_v[k[0]] = {1'b1, char_code};
            k = k + 1'b1;
            col_nxt = col_nxt + 1'b1;
          end else begin
            abort = 1'b1;
          end
        end
        if (!abort && int'(col_nxt) >= COLUMNS) begin
          nl_nxt = 1'b1;
        end
        if (abort) begin
          status = ST_FULL;
        end
      end
      OP_CURSOR: begin
        if (int'(cursor_row) >= ROWS || int'(cursor_col) >= COLUMNS) begin
          status = ST_RANGE;
        end else if (qstat.free == '0) begin
          status = ST_FULL;
        end else begin
          addr = addr_t'(base_r[cursor_row[ROWSEL_W-1:0]] + addr_t'(cursor_col));
          cmd_v[0] = {1'b0, CMD_SET_ADDR | {1'b0, addr}};
          k = 2'd1;
        end
      end
      OP_CLEAR: begin
        if (qstat.free == '0) begin
          status = ST_FULL;
        end else begin
          cmd_v[0] = {1'b0, CMD_CLEAR};
          k = 2'd1;
        end
      end
      OP_POLL: begin
        pop = !busy_req && (qstat.count != '0);
      end
      OP_RAW: begin
        if (qstat.free == '0) begin
          status = ST_FULL;
        end else begin
          cmd_v[0] = {raw_rs, char_code};
          k = 2'd1;
        end
      end
      default: begin
      end
    endcase
    push_n = k;
  end

  assign qreq.push_n = take ? push_n : 2'd0;
  assign qreq.pop    = take && pop;
  assign qreq.d0     = cmd_v[0];
  assign qreq.d1     = cmd_v[1];

  assign port_write   = pop;
  assign port_rs      = pop ? qstat.head[8] : 1'b0;
  assign port_data    = pop ? qstat.head[7:0] : 8'h00;
  assign count_after  = qstat.count + qcnt_t'(push_n) - qcnt_t'(pop);
  assign queued_count = CNT_OUT_W'(count_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      nl_r   <= 1'b0;
      base_r <= ROW_BASE_RST;
    end else begin
      if (take) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        nl_r  <= nl_nxt;
      end
      if (cfg_we) begin
        base_r[cfg_index] <= cfg_wdata;
      end
    end
  end

endmodule

[hdl/char_lcd_terminal_queue_top.sv]
`timescale 1ns / 1ps

// character lcd front end: a ring queue of display commands plus a tracked
// text cursor for a 16 column by 4 row panel
// input channel (in_valid / in_ready) carries one op per beat: write char,
// set cursor, clear, poll tick or raw push
// output channel (out_valid / out_ready) returns exactly one result beat per
// input beat: status, the command sent to the panel on a poll tick, and the
// number of commands still queued
// the queue holds at most 15 commands; a full queue gives status 1 and keeps
// the sub-steps of a write char that were already done
// latency: the result is valid in the cycle after the input beat
// throughput: one beat per cycle while out_ready is high, set by the single result register
// a stalled receiver holds the result register; in_ready stays high as long
// as the result register is empty or is being drained in the same cycle
// row base registers are written through cfg_we / cfg_index / cfg_wdata;
// the user must do this only while the block is idle; it is not enforced
// reset (synchronous, active low) empties the queue, homes the cursor,
// clears the pending newline and loads the default row bases

module char_lcd_terminal_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [7:0] in_char_code,
  input  logic       in_raw_rs,
  input  logic [4:0] in_cursor_col,
  input  logic [2:0] in_cursor_row,
  input  logic       in_busy_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_port_write,
  output logic       out_port_rs,
  output logic [7:0] out_port_data,
  output logic [3:0] out_queued_count
);
  import lcdq_pkg::*;

  q_req_t  qreq;
  q_stat_t qstat;
  logic    take;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic [1:0] status;
  logic       port_write;
  logic       port_rs;
  logic [7:0] port_data;
  logic [CNT_OUT_W-1:0] queued_count;
  logic [1:0] status_r;
  logic       port_write_r;
  logic       port_rs_r;
  logic [7:0] port_data_r;
  logic [CNT_OUT_W-1:0] queued_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  lcdq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .op           (in_op),
    .char_code    (in_char_code),
    .raw_rs       (in_raw_rs),
    .cursor_col   (in_cursor_col),
    .cursor_row   (in_cursor_row),
    .busy_req     (in_busy_req),
    .qstat        (qstat),
    .qreq         (qreq),
    .status       (status),
    .port_write   (port_write),
    .port_rs      (port_rs),
    .port_data    (port_data),
    .queued_count (queued_count)
  );

  lcdq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (qreq),
    .stat  (qstat)
  );

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r       <= status;
      port_write_r   <= port_write;
      port_rs_r      <= port_rs;
      port_data_r    <= port_data;
      queued_count_r <= queued_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_port_write   = port_write_r;
  assign out_port_rs      = port_rs_r;
  assign out_port_data    = port_data_r;
  assign out_queued_count = queued_count_r;

endmodule

[hdl/lcdq_checker.sv]
`timescale 1ns / 1ps

module lcdq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_op,
  input logic [4:0] in_cursor_col,
  input logic [2:0] in_cursor_row,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_port_write,
  input logic       out_port_rs,
  input logic [7:0] out_port_data
);
  import lcdq_pkg::*;

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  // bad cursor position reported on the next cycle
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_CURSOR &&
    (in_cursor_row >= 3'd4 || in_cursor_col >= 5'd16)
    |=> out_valid && out_status == ST_RANGE && !out_port_write)
    else $error("cursor range error not reported");

  // every accepted beat yields a result beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat without result");

  // idle port fields stay zero when nothing is sent
  a_port_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_port_write |-> !out_port_rs && out_port_data == 8'h00)
    else $error("port fields set without a send");

  // status code never out of range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("invalid status code");

endmodule

bind char_lcd_terminal_queue_top lcdq_checker u_lcdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_op          (in_op),
  .in_cursor_col  (in_cursor_col),
  .in_cursor_row  (in_cursor_row),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_port_write (out_port_write),
  .out_port_rs    (out_port_rs),
  .out_port_data  (out_port_data)
);
